// ----- hw/rtl/jadc_pkg.sv -----
// Package for the joystick axis conditioning block: widths, register codes,
// fixed-point constants and the structs passed between pipeline sections.
// No dependencies; every other file imports it.
package jadc_pkg;

  localparam int AXIS_COUNT = 4;
  localparam int FRAC_BITS  = 16;

  localparam int CAL_REGS  = 4;
  localparam int CAL_IDX_W = 2;
  localparam int RAW_W     = 16;
  localparam int AXIS_W    = 2;
  localparam int POS_W     = 18;
  localparam int STAT_W    = 2;
  localparam int FIELD_W   = 17;
  localparam int CAL_W     = 3 * FIELD_W;
  localparam int PCT_W     = 7;
  localparam int SENS_W    = 4;
  localparam int CFG_IDX_W = 3;

  localparam int MIN_HALF_SPAN = 5;
  localparam int PCT_FULL      = 100;
  localparam int SENS_FULL     = 9;
  localparam int OUT_FRAC      = 16;

  localparam logic [FIELD_W-1:0] RESET_CENTER = 17'd32768;
  localparam logic [FIELD_W-1:0] RESET_MIN    = 17'd0;
  localparam logic [FIELD_W-1:0] RESET_MAX    = 17'd65536;
  localparam logic [CAL_W-1:0]   CAL_RESET    = {RESET_MAX, RESET_MIN, RESET_CENTER};
  localparam logic [PCT_W-1:0]   PCT_RESET    = 7'd10;
  localparam logic [SENS_W-1:0]  SENS_RESET   = 4'd9;

  // Divider: quotient floor(num * 2^Q_FRAC / den) with num <= den
  localparam int Q_FRAC     = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS : OUT_FRAC;
  localparam int Q_W        = Q_FRAC + 1;
  localparam int DIV_STAGES = Q_W;
  localparam int REM_W      = FIELD_W + 1;

  localparam int ONE_W   = FRAC_BITS + 1;
  localparam int LIN_W   = OUT_FRAC + 1;
  localparam int OUT_SHR = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam int OUT_SHL = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;

  // Dead zone: span * pct / 100 through a reciprocal multiply
  localparam int     DZP_W      = FIELD_W + PCT_W;
  localparam int     DZ_SHIFT   = DZP_W + 7;
  localparam int     DZ_RECIP_W = DZ_SHIFT - 6;
  localparam longint DZ_RECIP   = ((longint'(1) << DZ_SHIFT) + PCT_FULL - 1) / PCT_FULL;

  // Curve blend: sum / 9 through a reciprocal multiply
  localparam int     SUM_W        = FRAC_BITS + 5;
  localparam int     DIV9_SHIFT   = FRAC_BITS + 8;
  localparam int     DIV9_RECIP_W = FRAC_BITS + 5;
  localparam longint DIV9_RECIP   = ((longint'(1) << DIV9_SHIFT) + SENS_FULL - 1) / SENS_FULL;

  localparam logic CMD_CENTERED = 1'b0;
  localparam logic CMD_LINEAR   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS0,
    CFG_AXIS1,
    CFG_AXIS2,
    CFG_AXIS3,
    CFG_DEAD_ZONE,
    CFG_SENS
  } cfg_idx_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK,
    STAT_CAL_BAD,
    STAT_EMPTY
  } status_e;

  typedef struct packed {
    logic [CAL_REGS-1:0][CAL_W-1:0] cal;
    logic [PCT_W-1:0]               dz_pct;
    logic [SENS_W-1:0]              sens;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cal:    {CAL_REGS{CAL_RESET}},
    dz_pct: PCT_RESET,
    sens:   SENS_RESET
  };

  typedef struct packed {
    logic    cmd;
    logic    neg;
    status_e status;
  } meta_t;

  typedef struct packed {
    logic [FIELD_W-1:0] num;
    logic [FIELD_W-1:0] den;
    meta_t              meta;
  } div_req_t;

  typedef struct packed {
    logic [Q_W-1:0] quo;
    meta_t          meta;
  } div_rsp_t;

endpackage

// ----- hw/rtl/jadc_in_if.sv -----
// Sample channel: valid/ready handshake carrying one raw axis sample.
// Depends on jadc_pkg for field widths.
interface jadc_in_if import jadc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RAW_W-1:0]  raw_sample;
  logic [AXIS_W-1:0] axis_number;
  logic              cmd;

  modport source (output valid, raw_sample, axis_number, cmd, input ready);
  modport sink   (input valid, raw_sample, axis_number, cmd, output ready);
endinterface

// ----- hw/rtl/jadc_out_if.sv -----
// Result channel: valid/ready handshake carrying the conditioned position.
// Depends on jadc_pkg for field widths.
interface jadc_out_if import jadc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position;
  logic [STAT_W-1:0]       status;

  modport source (output valid, position, status, input ready);
  modport sink   (input valid, position, status, output ready);
endinterface

// ----- hw/rtl/jadc_front.sv -----
// Front section: calibration select and checks, dead zone, side selection.
// Three pipeline stages; produces numerator/denominator for jadc_div. Uses jadc_pkg.
module jadc_front import jadc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  jadc_in_if.sink  sample_i,
  input  cfg_t     cfg_i,
  output logic     req_valid_o,
  input  logic     req_ready_i,
  output div_req_t req_o
);

  localparam int SW = FIELD_W + 2;

  logic va_q, vb_q, vc_q;
  logic en_a, en_b, en_c;

  // stage A inputs
  logic                 axis_ok;
  logic [CAL_W-1:0]     cal_sel;
  logic [FIELD_W-1:0]   c_w, mn_w, mx_w, span_w, lin_w;
  logic signed [SW-1:0] cmn_w, mxc_w, rc_w, rm_w;
  logic [PCT_W-1:0]     pct_w;
  logic [DZP_W-1:0]     prod_w;
  logic                 bad_w;

  logic                 cmd_a_q, bad_a_q;
  logic [FIELD_W-1:0]   span_a_q, lin_a_q;
  logic signed [SW-1:0] cmn_a_q, mxc_a_q, rc_a_q;
  logic [DZP_W-1:0]     prod_a_q;

  // stage B
  logic [DZP_W+DZ_RECIP_W-1:0] dzm_w;
  logic                 cmd_b_q, bad_b_q;
  logic [FIELD_W-1:0]   span_b_q, lin_b_q, dz_b_q;
  logic signed [SW-1:0] cmn_b_q, mxc_b_q, rc_b_q;

  // stage C
  logic signed [SW-1:0] dz_s, nr_w, rng_w, dist_w, dcl_w;
  logic                 side_neg, side_pos, empty_w;
  div_req_t             req_d, req_q;

  assign en_c = !vc_q || req_ready_i;
  assign en_b = !vb_q || en_c;
  assign en_a = !va_q || en_b;
  assign sample_i.ready = en_a;

  always_comb begin
    axis_ok = 32'(sample_i.axis_number) < AXIS_COUNT;
    cal_sel = axis_ok ? cfg_i.cal[sample_i.axis_number] : '0;
    c_w     = cal_sel[FIELD_W-1:0];
    mn_w    = cal_sel[2*FIELD_W-1:FIELD_W];
    mx_w    = cal_sel[3*FIELD_W-1:2*FIELD_W];
    cmn_w   = $signed({2'b00, c_w}) - $signed({2'b00, mn_w});
    mxc_w   = $signed({2'b00, mx_w}) - $signed({2'b00, c_w});
    bad_w   = !axis_ok || (cmn_w < $signed(SW'(MIN_HALF_SPAN)))
              || (mxc_w < $signed(SW'(MIN_HALF_SPAN)));
    span_w  = mx_w - mn_w;
    rc_w    = $signed({3'b000, sample_i.raw_sample}) - $signed({2'b00, c_w});
    rm_w    = $signed({3'b000, sample_i.raw_sample}) - $signed({2'b00, mn_w});
    // clamp the linear offset to the calibrated span
    if (rm_w < 0) begin
      lin_w = '0;
    end else if (rm_w > $signed({2'b00, span_w})) begin
      lin_w = span_w;
    end else begin
      lin_w = rm_w[FIELD_W-1:0];
    end
    pct_w  = (cfg_i.dz_pct > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : cfg_i.dz_pct;
    prod_w = DZP_W'(span_w) * DZP_W'(pct_w);
  end

  assign dzm_w = (DZP_W+DZ_RECIP_W)'(prod_a_q) * (DZP_W+DZ_RECIP_W)'(DZ_RECIP);

  always_comb begin
    dz_s     = $signed({2'b00, dz_b_q});
    nr_w     = -rc_b_q;
    side_neg = nr_w > dz_s;
    side_pos = rc_b_q > dz_s;
    rng_w    = side_neg ? (cmn_b_q - dz_s) : (mxc_b_q - dz_s);
    dist_w   = side_neg ? (nr_w - dz_s) : (rc_b_q - dz_s);
    empty_w  = !(side_neg || side_pos) || !(rng_w > 0);
    dcl_w    = (dist_w > rng_w) ? rng_w : dist_w;

    req_d.meta.cmd = cmd_b_q;
    req_d.meta.neg = side_neg;
    if (cmd_b_q == CMD_LINEAR) begin
      req_d.num = lin_b_q;
      req_d.den = span_b_q;
    end else begin
      req_d.num = dcl_w[FIELD_W-1:0];
      req_d.den = rng_w[FIELD_W-1:0];
    end
    if (bad_b_q) begin
      req_d.meta.status = STAT_CAL_BAD;
    end else if (cmd_b_q == CMD_LINEAR) begin
      req_d.meta.status = STAT_OK;
    end else if (empty_w) begin
      req_d.meta.status = STAT_EMPTY;
    end else begin
      req_d.meta.status = STAT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) va_q <= sample_i.valid;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && sample_i.valid) begin
      cmd_a_q  <= sample_i.cmd;
      bad_a_q  <= bad_w;
      span_a_q <= span_w;
      lin_a_q  <= lin_w;
      cmn_a_q  <= cmn_w;
      mxc_a_q  <= mxc_w;
      rc_a_q   <= rc_w;
      prod_a_q <= prod_w;
    end
    if (en_b && va_q) begin
      cmd_b_q  <= cmd_a_q;
      bad_b_q  <= bad_a_q;
      span_b_q <= span_a_q;
      lin_b_q  <= lin_a_q;
      cmn_b_q  <= cmn_a_q;
      mxc_b_q  <= mxc_a_q;
      rc_b_q   <= rc_a_q;
      dz_b_q   <= dzm_w[DZ_SHIFT +: FIELD_W];
    end
    if (en_c && vb_q) begin
      req_q <= req_d;
    end
  end

  assign req_valid_o = vc_q;
  assign req_o       = req_q;

  a_req_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vc_q && req_q.meta.status == STAT_OK) |-> (req_q.num <= req_q.den && req_q.den != '0))
    else $error("front: numerator exceeds span or empty span flagged normal");

endmodule

// ----- hw/rtl/jadc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Computes floor(num * 2^Q_FRAC / den) for num <= den. Uses jadc_pkg.
module jadc_div import jadc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  div_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output div_rsp_t rsp_o
);

  localparam int LAST = DIV_STAGES - 1;
  localparam logic [Q_W-1:0] Q_ONE = {1'b1, {Q_FRAC{1'b0}}};

  logic [DIV_STAGES-1:0] v_q;
  logic [DIV_STAGES:0]   en;
  logic [DIV_STAGES-1:0] vin_w, bit_w;

  logic [REM_W-1:0]   rem_q [DIV_STAGES];
  logic [REM_W-1:0]   rem_d [DIV_STAGES];
  logic [REM_W-1:0]   sh_w  [DIV_STAGES];
  logic [Q_W-1:0]     quo_q [DIV_STAGES];
  logic [Q_W-1:0]     quo_d [DIV_STAGES];
  logic [Q_W-1:0]     qp_w  [DIV_STAGES];
  logic [FIELD_W-1:0] den_q [DIV_STAGES];
  logic [FIELD_W-1:0] dn_w  [DIV_STAGES];
  meta_t              meta_q[DIV_STAGES];
  meta_t              mt_w  [DIV_STAGES];

  always_comb begin
    en[DIV_STAGES] = rsp_ready_i;
    for (int k = LAST; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    sh_w[0]  = REM_W'(req_i.num);
    dn_w[0]  = req_i.den;
    qp_w[0]  = '0;
    mt_w[0]  = req_i.meta;
    vin_w[0] = req_valid_i;
    for (int k = 1; k < DIV_STAGES; k++) begin
      // shift the partial remainder in for the next quotient bit
      sh_w[k]  = {rem_q[k-1][REM_W-2:0], 1'b0};
      dn_w[k]  = den_q[k-1];
      qp_w[k]  = quo_q[k-1];
      mt_w[k]  = meta_q[k-1];
      vin_w[k] = v_q[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      bit_w[k] = sh_w[k] >= REM_W'(dn_w[k]);
      rem_d[k] = bit_w[k] ? (sh_w[k] - REM_W'(dn_w[k])) : sh_w[k];
      quo_d[k] = {qp_w[k][Q_W-2:0], bit_w[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (en[k]) v_q[k] <= vin_w[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[k] && vin_w[k]) begin
        rem_q[k]  <= rem_d[k];
        quo_q[k]  <= quo_d[k];
        den_q[k]  <= dn_w[k];
        meta_q[k] <= mt_w[k];
      end
    end
  end

  assign req_ready_o = en[0];
  assign rsp_valid_o = v_q[LAST];
  assign rsp_o.quo   = quo_q[LAST];
  assign rsp_o.meta  = meta_q[LAST];

  a_quo_le_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[LAST] && meta_q[LAST].status == STAT_OK) |-> (quo_q[LAST] <= Q_ONE))
    else $error("div: quotient above one for a normal item");

endmodule

// ----- hw/rtl/jadc_curve.sv -----
// Curve section: p^2, p^4, p^5 products, sensitivity blend, divide by nine,
// sign and output register. Five stages; drives the result channel. Uses jadc_pkg.
module jadc_curve import jadc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rsp_valid_i,
  output logic       rsp_ready_o,
  input  div_rsp_t   rsp_i,
  input  cfg_t       cfg_i,
  jadc_out_if.source result_o
);

  localparam int STAGES = 5;
  localparam int LAST   = STAGES - 1;
  localparam logic signed [POS_W-1:0] POS_FULL = POS_W'(1 << OUT_FRAC);

  logic [STAGES-1:0] v_q;
  logic [STAGES:0]   en;
  logic [STAGES-1:0] vin_w;

  logic [ONE_W-1:0]   p_w;
  logic [LIN_W-1:0]   lin_w;
  logic [2*ONE_W-1:0] sq1_w, sq2_w, sq3_w;
  logic [SENS_W-1:0]  s_sat, s_inv;
  logic [SUM_W-1:0]   sum_w;
  logic [SUM_W+DIV9_RECIP_W-1:0] xm_w;
  logic [ONE_W-1:0]   x_w;
  logic signed [POS_W-1:0] mag_w, pos_d;

  logic [ONE_W-1:0] p1_q, p2_q, p3_q, pp2_q, pp4_q, pp5_q;
  logic [LIN_W-1:0] lin1_q, lin2_q, lin3_q, lin4_q;
  meta_t            m1_q, m2_q, m3_q, m4_q;
  logic [SUM_W-1:0] sum_q;
  logic signed [POS_W-1:0] pos_q;
  status_e          st_q;

  always_comb begin
    en[STAGES] = result_o.ready;
    for (int k = LAST; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    vin_w = {v_q[LAST-1:0], rsp_valid_i};
  end

  always_comb begin
    p_w   = ONE_W'(rsp_i.quo >> (Q_FRAC - FRAC_BITS));
    lin_w = LIN_W'(rsp_i.quo >> (Q_FRAC - OUT_FRAC));
    sq1_w = (2*ONE_W)'(p_w) * (2*ONE_W)'(p_w);
    sq2_w = (2*ONE_W)'(pp2_q) * (2*ONE_W)'(pp2_q);
    sq3_w = (2*ONE_W)'(pp4_q) * (2*ONE_W)'(p2_q);

    s_sat = (cfg_i.sens > SENS_W'(SENS_FULL)) ? SENS_W'(SENS_FULL) : cfg_i.sens;
    s_inv = SENS_W'(SENS_FULL) - s_sat;
    sum_w = SUM_W'(s_sat) * SUM_W'(p3_q) + SUM_W'(s_inv) * SUM_W'(pp5_q);

    xm_w  = (SUM_W+DIV9_RECIP_W)'(sum_q) * (SUM_W+DIV9_RECIP_W)'(DIV9_RECIP);
    x_w   = xm_w[DIV9_SHIFT +: ONE_W];
    mag_w = POS_W'(x_w >> OUT_SHR) << OUT_SHL;

    if (m4_q.status != STAT_OK) begin
      pos_d = '0;
    end else if (m4_q.cmd == CMD_LINEAR) begin
      pos_d = POS_W'(lin4_q);
    end else if (m4_q.neg) begin
      pos_d = -mag_w;
    end else begin
      pos_d = mag_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (en[k]) v_q[k] <= vin_w[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && vin_w[0]) begin
      p1_q   <= p_w;
      pp2_q  <= sq1_w[FRAC_BITS +: ONE_W];
      lin1_q <= lin_w;
      m1_q   <= rsp_i.meta;
    end
    if (en[1] && vin_w[1]) begin
      p2_q   <= p1_q;
      pp4_q  <= sq2_w[FRAC_BITS +: ONE_W];
      lin2_q <= lin1_q;
      m2_q   <= m1_q;
    end
    if (en[2] && vin_w[2]) begin
      p3_q   <= p2_q;
      pp5_q  <= sq3_w[FRAC_BITS +: ONE_W];
      lin3_q <= lin2_q;
      m3_q   <= m2_q;
    end
    if (en[3] && vin_w[3]) begin
      sum_q  <= sum_w;
      lin4_q <= lin3_q;
      m4_q   <= m3_q;
    end
    if (en[4] && vin_w[4]) begin
      pos_q <= pos_d;
      st_q  <= m4_q.status;
    end
  end

  assign rsp_ready_o       = en[0];
  assign result_o.valid    = v_q[LAST];
  assign result_o.position = pos_q;
  assign result_o.status   = st_q;

  a_zero_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[LAST] && st_q != STAT_OK) |-> (pos_q == '0))
    else $error("curve: nonzero position with fault status");

  a_full_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[LAST] |-> (pos_q <= POS_FULL && pos_q >= -POS_FULL))
    else $error("curve: position beyond full scale");

endmodule

// ----- hw/rtl/joystick_axis_deadzone_curve.sv -----
// Joystick axis conditioning, top level: configuration registers and the
// front / divider / curve pipeline. Uses jadc_pkg, jadc_in_if, jadc_out_if.
//
// Usage: sample_i carries one raw sample, its axis number and a mode bit
// (centered dead zone curve or linear mapping); result_o returns the
// conditioned position (65536 = full scale) and a status code. Every sample
// gives exactly one result, in order.
// Configuration: cfg_we_i writes cfg_data_i into the register named by
// cfg_index_i (four axis calibrations, dead zone percent, sensitivity);
// write only while no sample is in flight. Other indexes are ignored.
// Pipeline: a sample passes 3 front stages, one divider stage per quotient bit
// (17), and 5 curve stages before its result is valid.
// Throughput: one sample per cycle while result_o.ready stays high; the 17-stage
// divider and the chained 17x17 multipliers are fully pipelined.
// Reset: the calibrations return to center 32768, minimum 0, maximum 65536,
// dead zone to 10 percent, sensitivity to 9; the pipeline empties.
// Stall: when result_o.ready is low the finished result holds and earlier
// stages keep filling; sample_i.ready drops only once every stage is full.
module joystick_axis_deadzone_curve import jadc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  jadc_in_if.sink              sample_i,
  jadc_out_if.source           result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CAL_W-1:0]     cfg_data_i
);

  cfg_t     cfg_q;
  logic     dreq_valid, dreq_ready, drsp_valid, drsp_ready;
  div_req_t dreq;
  div_rsp_t drsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i) inside
        [CFG_AXIS0:CFG_AXIS3]: cfg_q.cal[cfg_index_i[CAL_IDX_W-1:0]] <= cfg_data_i;
        CFG_DEAD_ZONE:         cfg_q.dz_pct <= cfg_data_i[PCT_W-1:0];
        CFG_SENS:              cfg_q.sens   <= cfg_data_i[SENS_W-1:0];
        default: ;
      endcase
    end
  end

  jadc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .cfg_i       (cfg_q),
    .req_valid_o (dreq_valid),
    .req_ready_i (dreq_ready),
    .req_o       (dreq)
  );

  jadc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (dreq_valid),
    .req_ready_o (dreq_ready),
    .req_i       (dreq),
    .rsp_valid_o (drsp_valid),
    .rsp_ready_i (drsp_ready),
    .rsp_o       (drsp)
  );

  jadc_curve u_curve (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rsp_valid_i (drsp_valid),
    .rsp_ready_o (drsp_ready),
    .rsp_i       (drsp),
    .cfg_i       (cfg_q),
    .result_o    (result_o)
  );

endmodule

// ----- test/tb.sv -----
// Self-checking bench for joystick_axis_deadzone_curve: random-stall drive of the sample
// channel, in-order checking of conditioned positions against a local fixed-point predictor.
// Depends on jadc_pkg, jadc_in_if, jadc_out_if and the top level.
module tb;
  import jadc_pkg::*;

  localparam int PIPE_DEPTH  = 3 + DIV_STAGES + 5;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int SET_ITEMS   = 85;
  localparam int MAX_PRINTS  = 30;

  typedef struct packed {
    logic [RAW_W-1:0]  raw;
    logic [AXIS_W-1:0] axis;
    logic              cmd;
  } sample_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    status_e                 status;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 in_valid = 1'b0;
  sample_t              in_item = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CAL_W-1:0]     cfg_data = '0;

  jadc_in_if  sample_if ();
  jadc_out_if result_if ();

  assign sample_if.valid       = in_valid;
  assign sample_if.raw_sample  = in_item.raw;
  assign sample_if.axis_number = in_item.axis;
  assign sample_if.cmd         = in_item.cmd;
  assign result_if.ready       = out_ready;

  joystick_axis_deadzone_curve u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_if),
    .result_o    (result_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies used by the predictor
  logic [CAL_W-1:0]  cal_m [CAL_REGS] = '{default: CAL_RESET};
  logic [PCT_W-1:0]  dz_pct_m = PCT_RESET;
  logic [SENS_W-1:0] sens_m = SENS_RESET;

  sample_t  samples_to_send [$];
  outcome_t expected_positions [$];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  logic hold_go = 1'b0;
  logic rx_hold = 1'b0;
  logic in_took = 1'b0;
  int errors = 0;
  int stall_cycles = 0;
  int n_centered = 0;
  int n_linear = 0;
  int n_checked = 0;
  int n_settings = 0;
  int status_seen [3] = '{default: 0};

  function automatic outcome_t condition_sample(sample_t smp);
    outcome_t res;
    logic [CAL_W-1:0] cal;
    longint ctr, lo, hi, rel, dz, span, d, pct, v;
    longint unsigned p, p2, p4, p5, s, x;
    logic neg;
    res.position = '0;
    res.status = STAT_OK;
    if (smp.axis >= AXIS_COUNT) begin
      res.status = STAT_CAL_BAD;
      return res;
    end
    cal = cal_m[smp.axis];
    ctr = cal[FIELD_W-1:0];
    lo = cal[2*FIELD_W-1:FIELD_W];
    hi = cal[3*FIELD_W-1:2*FIELD_W];
    if (ctr - lo < MIN_HALF_SPAN || hi - ctr < MIN_HALF_SPAN) begin
      res.status = STAT_CAL_BAD;
      return res;
    end
    if (smp.cmd == CMD_LINEAR) begin
      span = hi - lo;
      rel = longint'(smp.raw) - lo;
      if (rel < 0) rel = 0;
      if (rel > span) rel = span;
      v = (rel << OUT_FRAC) / span;
      res.position = v[POS_W-1:0];
      return res;
    end
    rel = longint'(smp.raw) - ctr;
    pct = (dz_pct_m > PCT_FULL) ? PCT_FULL : dz_pct_m;
    dz = ((hi - lo) * pct) / PCT_FULL;
    if (rel < -dz) begin
      span = ctr - lo - dz;
      d = -rel - dz;
      neg = 1'b1;
    end else if (rel > dz) begin
      span = hi - ctr - dz;
      d = rel - dz;
      neg = 1'b0;
    end else begin
      res.status = STAT_EMPTY;
      return res;
    end
    if (span <= 0) begin
      res.status = STAT_EMPTY;
      return res;
    end
    if (d > span) d = span;
    s = (sens_m > SENS_FULL) ? SENS_FULL : sens_m;
    p = (unsigned'(d) << FRAC_BITS) / unsigned'(span);
    if (p > (64'd1 << FRAC_BITS)) p = 64'd1 << FRAC_BITS;
    p2 = (p * p) >> FRAC_BITS;
    p4 = (p2 * p2) >> FRAC_BITS;
    p5 = (p4 * p) >> FRAC_BITS;
    x = (s * p + (SENS_FULL - s) * p5) / SENS_FULL;
    if (FRAC_BITS >= OUT_FRAC) x = x >> (FRAC_BITS - OUT_FRAC);
    else x = x << (OUT_FRAC - FRAC_BITS);
    v = neg ? -longint'(x) : longint'(x);
    res.position = v[POS_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("MISMATCH result %0d: %s got %0d expected %0d", n_checked, what, got, want);
  endtask

  // Acceptance, prediction, checking and the watchdog, all on the rising edge
  always @(posedge clk_i) begin
    outcome_t want;
    sample_t smp;
    logic out_took;
    in_took = in_valid && sample_if.ready;
    out_took = result_if.valid && out_ready;
    if (in_took) begin
      smp.raw = sample_if.raw_sample;
      smp.axis = sample_if.axis_number;
      smp.cmd = sample_if.cmd;
      want = condition_sample(smp);
      expected_positions.push_back(want);
      void'(samples_to_send.pop_front());
      if (smp.cmd == CMD_LINEAR) n_linear++;
      else n_centered++;
      status_seen[want.status]++;
    end
    if (out_took) begin
      if (expected_positions.size() == 0) begin
        report_mismatch("unexpected result, position", longint'(result_if.position), 0);
      end else begin
        want = expected_positions.pop_front();
        if (result_if.position !== want.position)
          report_mismatch("position", longint'(result_if.position), longint'(want.position));
        if (result_if.status !== want.status)
          report_mismatch("status", result_if.status, want.status);
      end
      n_checked++;
    end
    if (in_took || out_took || (samples_to_send.size() == 0 && expected_positions.size() == 0))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("joystick_axis_deadzone_curve verification failed");
      $finish;
    end
  end

  // Sample driver: hold the offered sample until its transfer
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_took)) begin
      if (samples_to_send.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_valid <= 1'b1;
        in_item <= samples_to_send[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= rcv_idle_pct);
  end

  // Long receiver hold-off so the pipeline fills and backs up the input
  initial begin
    wait (hold_go);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  function automatic logic [CAL_W-1:0] pack_cal(input int unsigned ctr, lo, hi);
    return {FIELD_W'(hi), FIELD_W'(lo), FIELD_W'(ctr)};
  endfunction

  function automatic logic [CAL_W-1:0] random_cal();
    int unsigned lo, hi, ctr, pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      lo = $urandom_range(0, 30000);
      hi = $urandom_range(35000, 131071);
      ctr = $urandom_range(lo + 5, hi - 5);
    end else if (pick < 85) begin
      // narrowest spans: 5 to 25 counts each side of center
      lo = $urandom_range(0, 65000);
      ctr = lo + 5 + $urandom_range(0, 20);
      hi = ctr + 5 + $urandom_range(0, 20);
    end else begin
      return CAL_W'({$urandom, $urandom});
    end
    return pack_cal(ctr, lo, hi);
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CAL_W-1:0] val);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      CFG_DEAD_ZONE: dz_pct_m = val[PCT_W-1:0];
      CFG_SENS:      sens_m = val[SENS_W-1:0];
      default:       cal_m[int'(idx)] = val;
    endcase
  endtask

  task automatic queue_sample(input int raw, input int axis, input logic cmd);
    sample_t smp;
    smp.raw = RAW_W'(raw);
    smp.axis = AXIS_W'(axis);
    smp.cmd = cmd;
    samples_to_send.push_back(smp);
  endtask

  // Mostly aim at the dead zone edges, the center and the calibration ends
  task automatic queue_random(input int count);
    logic [CAL_W-1:0] cal;
    longint ctr, lo, hi, pct, dzv, v;
    int pick, axis;
    logic cmd;
    for (int i = 0; i < count; i++) begin
      axis = $urandom_range(0, 3);
      cmd = ($urandom_range(99) < 70) ? CMD_CENTERED : CMD_LINEAR;
      cal = cal_m[axis];
      ctr = cal[FIELD_W-1:0];
      lo = cal[2*FIELD_W-1:FIELD_W];
      hi = cal[3*FIELD_W-1:2*FIELD_W];
      pct = (dz_pct_m > PCT_FULL) ? PCT_FULL : dz_pct_m;
      dzv = (hi > lo) ? ((hi - lo) * pct) / PCT_FULL : 0;
      pick = $urandom_range(99);
      if (pick < 40) v = $urandom_range(0, 65535);
      else if (pick < 70) v = dzv + $urandom_range(0, 4) - 2;
      else if (pick < 85) v = $urandom_range(0, 2000);
      else v = $urandom_range(0, 8) - 4;
      if (pick >= 40 && pick < 85) begin
        if ($urandom_range(1)) v = -v;
        v = ctr + v;
      end else if (pick >= 85) begin
        v = ($urandom_range(1) ? lo : hi) + v;
      end
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      queue_sample(int'(v), axis, cmd);
    end
  endtask

  task automatic wait_idle();
    while (samples_to_send.size() != 0 || expected_positions.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 5) @(posedge clk_i);
  endtask

  initial begin
    int dz_val, sens_val;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    snd_idle_pct = 23;
    rcv_idle_pct = 57;

    // Reset calibration: full swings, dead zone edges, linear ends
    n_settings++;
    queue_sample(0, 0, CMD_CENTERED);
    queue_sample(65535, 0, CMD_CENTERED);
    queue_sample(32768, 1, CMD_CENTERED);
    queue_sample(32768 + 6553, 1, CMD_CENTERED);
    queue_sample(32768 + 6554, 2, CMD_CENTERED);
    queue_sample(32768 - 6554, 2, CMD_CENTERED);
    queue_sample(0, 3, CMD_LINEAR);
    queue_sample(65535, 3, CMD_LINEAR);
    queue_sample(21845, 0, CMD_LINEAR);
    queue_sample(40000, 1, CMD_CENTERED);
    wait_idle();

    // Bad calibrations, widest and narrowest spans, saturating percent and sensitivity
    n_settings++;
    write_reg(CFG_AXIS0, pack_cal(100, 96, 60000));
    write_reg(CFG_AXIS1, pack_cal(65535, 0, 131071));
    write_reg(CFG_AXIS2, pack_cal(10, 5, 15));
    write_reg(CFG_AXIS3, pack_cal(131071, 131071, 131071));
    write_reg(CFG_DEAD_ZONE, CAL_W'(127));
    write_reg(CFG_SENS, CAL_W'(15));
    queue_sample(5000, 0, CMD_CENTERED);
    queue_sample(5000, 0, CMD_LINEAR);
    queue_sample(0, 1, CMD_CENTERED);
    queue_sample(65535, 2, CMD_CENTERED);
    queue_sample(65535, 1, CMD_LINEAR);
    queue_sample(0, 2, CMD_LINEAR);
    queue_sample(65535, 2, CMD_LINEAR);
    queue_sample(65535, 3, CMD_CENTERED);
    wait_idle();

    // No dead zone, pure fifth-power curve, samples beyond the calibrated range
    n_settings++;
    write_reg(CFG_AXIS0, CAL_RESET);
    write_reg(CFG_AXIS3, pack_cal(40000, 30000, 50000));
    write_reg(CFG_DEAD_ZONE, CAL_W'(0));
    write_reg(CFG_SENS, CAL_W'(0));
    queue_sample(32768, 0, CMD_CENTERED);
    queue_sample(32769, 0, CMD_CENTERED);
    queue_sample(32767, 0, CMD_CENTERED);
    queue_sample(49152, 0, CMD_CENTERED);
    queue_sample(65535, 3, CMD_CENTERED);
    queue_sample(0, 3, CMD_CENTERED);
    queue_sample(15, 2, CMD_CENTERED);
    queue_sample(12, 2, CMD_CENTERED);
    wait_idle();

    for (int set_no = 0; set_no < 8; set_no++) begin
      if (set_no == 3) begin
        snd_idle_pct = 57;
        rcv_idle_pct = 23;
      end else if (set_no == 6) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      case (set_no)
        0: begin dz_val = 0; sens_val = 15; end
        1: begin dz_val = 127; sens_val = 0; end
        2: begin dz_val = 100; sens_val = 9; end
        default: begin
          dz_val = ($urandom_range(3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 30);
          sens_val = $urandom_range(0, 15);
        end
      endcase
      n_settings++;
      write_reg(CFG_AXIS0, random_cal());
      write_reg(CFG_AXIS1, random_cal());
      write_reg(CFG_AXIS2, random_cal());
      write_reg(CFG_AXIS3, random_cal());
      write_reg(CFG_DEAD_ZONE, CAL_W'(dz_val));
      write_reg(CFG_SENS, CAL_W'(sens_val));
      if (set_no == 6) hold_go = 1'b1;
      queue_random(SET_ITEMS);
      wait_idle();
    end

    $display("Run covered %0d centered and %0d linear samples over %0d register settings",
             n_centered, n_linear, n_settings);
    $display("Statuses predicted: %0d normal, %0d bad calibration, %0d dead zone or empty span;"
             , status_seen[0], status_seen[1], status_seen[2]);
    $display("%0d results checked, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("joystick_axis_deadzone_curve verification clean");
    end else begin
      $display("joystick_axis_deadzone_curve verification failed");
    end
    $finish;
  end

endmodule
